### hw/rtl/tss_pkg.sv
// Shared widths, field layout, types and slot hash for the three-sum index search.
package tss_pkg;

  localparam int unsigned MAX_ITEMS = 4096;
  localparam int unsigned VAL_W     = 30;
  localparam int unsigned POS_W     = 13;
  localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
  // lookup table holds at least twice as many slots as values, so probing ends
  localparam int unsigned SLOT_W    = ADDR_W + 1;
  localparam int unsigned SLOTS     = 2 ** SLOT_W;
  localparam int unsigned FOLDS     = (VAL_W + SLOT_W - 1) / SLOT_W;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 48;

  // output word layout
  localparam int unsigned OUT_FOUND  = 0;
  localparam int unsigned OUT_FIRST  = OUT_FOUND + 1;
  localparam int unsigned OUT_SECOND = OUT_FIRST + POS_W;
  localparam int unsigned OUT_THIRD  = OUT_SECOND + POS_W;
  localparam int unsigned OUT_OVF    = OUT_THIRD + POS_W;
  localparam int unsigned OUT_USED   = OUT_OVF + 1;

  typedef struct packed {
    logic              used;
    logic [VAL_W-1:0]  key;
    logic [ADDR_W-1:0] pos;
  } slot_t;

  localparam int unsigned SLOT_DATA_W = $bits(slot_t);

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] second;
    logic [POS_W-1:0] third;
  } result_t;

  // fold the value into a slot number
  function automatic logic [SLOT_W-1:0] slot_home(input logic [VAL_W-1:0] key);
    logic [FOLDS*SLOT_W-1:0] ext;
    logic [SLOT_W-1:0]       h;
    ext = '0;
    ext[VAL_W-1:0] = key;
    h = '0;
    for (int unsigned f = 0; f < FOLDS; f++) begin
      h = h ^ ext[f*SLOT_W +: SLOT_W];
    end
    return h;
  endfunction

endpackage

### hw/rtl/tss_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module tss_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### hw/rtl/tss_search.sv
// Search sequencer: clears the lookup table, walks pairs and probes for the third value.
module tss_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tss_pkg::CNT_W-1:0]   count_i,
  input  logic [tss_pkg::VAL_W-1:0]   target_i,
  output logic [tss_pkg::ADDR_W-1:0]  vraddr_o,
  input  logic [tss_pkg::VAL_W-1:0]   vrdata_i,
  output logic                        res_valid_o,
  output tss_pkg::result_t            res_o,
  input  logic                        res_ack_i
);
  import tss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_I_RD,
    S_I_WT,
    S_J_RD,
    S_J_WT,
    S_HASH,
    S_PR_RD,
    S_PR_CHK,
    S_PUT_RD,
    S_PUT_CHK,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  i_q, i_d, j_q, j_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [VAL_W-1:0]  vi_q, vi_d, need_q, need_d;
  result_t           res_q, res_d;

  logic              twe;
  slot_t             twdata, trdata;
  logic [VAL_W:0]    pair;

  tss_ram #(
    .DEPTH (SLOTS),
    .WIDTH (SLOT_DATA_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (twe),
    .waddr_i (slot_q),
    .wdata_i (twdata),
    .raddr_i (slot_q),
    .rdata_o (trdata)
  );

  assign pair = {1'b0, vi_q} + {1'b0, vrdata_i};

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    slot_d   = slot_q;
    vi_d     = vi_q;
    need_d   = need_q;
    res_d    = res_q;
    twe      = 1'b0;
    twdata   = '0;
    vraddr_o = i_q[ADDR_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          slot_d  = '0;
          state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        twe    = 1'b1;
        slot_d = slot_q + SLOT_W'(1);
        if (slot_q == SLOT_W'(SLOTS - 1)) begin
          i_d     = '0;
          state_d = S_I_RD;
        end
      end
      S_I_RD: begin
        if (i_q >= count_i) begin
          res_d   = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_I_WT;
        end
      end
      S_I_WT: begin
        vi_d    = vrdata_i;
        j_d     = i_q + CNT_W'(1);
        state_d = S_J_RD;
      end
      S_J_RD: begin
        vraddr_o = j_q[ADDR_W-1:0];
        if (j_q >= count_i) begin
          slot_d  = slot_home(vi_q);
          state_d = S_PUT_RD;
        end else begin
          state_d = S_J_WT;
        end
      end
      S_J_WT: begin
        if (pair <= {1'b0, target_i}) begin
          need_d  = VAL_W'({1'b0, target_i} - pair);
          state_d = S_HASH;
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_J_RD;
        end
      end
      S_HASH: begin
        slot_d  = slot_home(need_q);
        state_d = S_PR_RD;
      end
      S_PR_RD: begin
        state_d = S_PR_CHK;
      end
      S_PR_CHK: begin
        if (!trdata.used) begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_J_RD;
        end else if (trdata.key == need_q) begin
          res_d.found  = 1'b1;
          res_d.first  = POS_W'(CNT_W'(trdata.pos) + CNT_W'(1));
          res_d.second = POS_W'(j_q + CNT_W'(1));
          res_d.third  = POS_W'(i_q + CNT_W'(1));
          state_d      = S_DONE;
        end else begin
          slot_d  = slot_q + SLOT_W'(1);
          state_d = S_PR_RD;
        end
      end
      S_PUT_RD: begin
        state_d = S_PUT_CHK;
      end
      S_PUT_CHK: begin
        if (!trdata.used || trdata.key == vi_q) begin
          // overwrite keeps the latest position of each value
          twe         = 1'b1;
          twdata.used = 1'b1;
          twdata.key  = vi_q;
          twdata.pos  = i_q[ADDR_W-1:0];
          i_d         = i_q + CNT_W'(1);
          state_d     = S_I_RD;
        end else begin
          slot_d  = slot_q + SLOT_W'(1);
          state_d = S_PUT_RD;
        end
      end
      S_DONE: begin
        if (res_ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      slot_q  <= '0;
      vi_q    <= '0;
      need_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      slot_q  <= slot_d;
      vi_q    <= vi_d;
      need_q  <= need_d;
      res_q   <= res_d;
    end
  end

  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

### hw/rtl/three_sum_index_search.sv
// Top level: list loading, target register, search control and result register.
//
//   channel  | dir | word                                        | accepted when
//   s_axis   | in  | tdata: value[29:0]; tlast: last item        | tvalid & tready
//   m_axis   | out | tdata: found, first, second, third, overflow | tvalid & tready
//   cfg      | in  | data: target_sum[29:0]                      | valid & ready
//
// Loading takes one word per cycle, while s_axis_tready_o is high, into the value
// RAM. After the last word the search runs with s_axis_tready_o low: a sweep clears
// the lookup table, then for each outer position the inner positions are read, each
// pair within the target probes the table for the third value, and the outer value
// is then inserted. Reset clears control state only; the table sweep runs per list.
// A result waiting on m_axis does not block loading of the next list.
module three_sum_index_search (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [tss_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // [29:0] value
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] found, [13:1] first, [26:14] second, [39:27] third, [40] overflow
  output logic [tss_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tss_pkg::VAL_W-1:0]      cfg_data_i
);
  import tss_pkg::*;

  logic                  busy_q, start_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  drop_q, drop_d;
  logic [VAL_W-1:0]      target_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic                  in_fire, full, out_load;
  logic [ADDR_W-1:0]     vraddr;
  logic [VAL_W-1:0]      vrdata;
  logic                  res_valid;
  result_t               res;

  assign s_axis_tready_o = !busy_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CNT_W'(MAX_ITEMS));
  assign cfg_ready_o     = 1'b1;
  assign out_load        = res_valid && (!out_valid_q || m_axis_tready_i);

  tss_ram #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (VAL_W)
  ) u_values (
    .clk_i   (clk_i),
    .we_i    (in_fire && !full),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (s_axis_tdata_i[VAL_W-1:0]),
    .raddr_i (vraddr),
    .rdata_o (vrdata)
  );

  tss_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .count_i     (count_q),
    .target_i    (target_q),
    .vraddr_o    (vraddr),
    .vrdata_i    (vrdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ack_i   (out_load)
  );

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (out_load) begin
      count_d = '0;
      drop_d  = 1'b0;
    end else if (in_fire) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      start_q  <= 1'b0;
      count_q  <= '0;
      drop_q   <= 1'b0;
      target_q <= '0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
      start_q <= in_fire && s_axis_tlast_i;
      if (in_fire && s_axis_tlast_i) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        target_q <= cfg_data_i;
      end
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {{(OUT_DATA_W - OUT_USED){1'b0}}, drop_q,
                     res.third, res.second, res.first, res.found};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

### hw/rtl/tss_checker.sv
// Port-level checks for the three-sum index search, bound to the top level.
module tss_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           s_axis_tlast_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [tss_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import tss_pkg::*;

  logic             found;
  logic [POS_W-1:0] first, second, third;

  assign found  = m_axis_tdata_o[OUT_FOUND];
  assign first  = m_axis_tdata_o[OUT_FIRST +: POS_W];
  assign second = m_axis_tdata_o[OUT_SECOND +: POS_W];
  assign third  = m_axis_tdata_o[OUT_THIRD +: POS_W];

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // the last word starts the search, so input closes next cycle
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input still open after last word");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !found |-> first == '0 && second == '0 && third == '0)
    else $error("positions not zero on a miss");

  // k below i below j, all 1-based
  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && found |-> first != '0 && first < third && third < second)
    else $error("positions out of order on a hit");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_DATA_W-1:OUT_USED] == '0)
    else $error("padding bits set in result word");

endmodule

bind three_sum_index_search tss_checker u_tss_checker (.*);
